// ===== rtl/rtos_ready_and_delay_scheduler_unit_assert.svh =====
// Assertion macros for the scheduler block.
`ifndef RTOS_READY_AND_DELAY_SCHEDULER_UNIT_ASSERT_SVH
`define RTOS_READY_AND_DELAY_SCHEDULER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define RRDS_ASSERT_HOLD(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
    else $error("rrds: invariant broken");
`define RRDS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rrds: sequence broken");
`else
`define RRDS_ASSERT_HOLD(lbl, clk, rstn, expr)
`define RRDS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/rrds_pkg.sv =====
// Shared types and constants of the scheduler block.
package rrds_pkg;
    localparam int ID_W   = 8;
    localparam int CNT_W  = 9;
    localparam int PRIO_W = 5;

    localparam logic [2:0] CMD_RADD  = 3'd0;
    localparam logic [2:0] CMD_RREM  = 3'd1;
    localparam logic [2:0] CMD_DINS  = 3'd2;
    localparam logic [2:0] CMD_DREM  = 3'd3;
    localparam logic [2:0] CMD_TICK  = 3'd4;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_RADD,
        OP_RREM,
        OP_DLINK,
        OP_DREM,
        OP_TICK
    } t_op;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        t_op               op;
        logic [ID_W-1:0]   tgt;
        logic [PRIO_W-1:0] prio;
        logic [CNT_W-1:0]  rdy_cnt;
        logic [CNT_W-1:0]  tr_rank;
        logic [CNT_W-1:0]  tr_dpos;
        logic [CNT_W-1:0]  ins_pos;
        logic [CNT_W-1:0]  k;
        logic              dec;
    } t_bcast;

    // running result handed from cell to cell
    typedef struct packed {
        logic              hit_ready;
        logic              hit_delay;
        logic [CNT_W-1:0]  hit_rank;
        logic [CNT_W-1:0]  hit_dpos;
        logic [CNT_W-1:0]  lt_cnt;
        logic [CNT_W-1:0]  z_cnt;
        logic [CNT_W-1:0]  o_cnt;
        logic              best_vld;
        logic [PRIO_W-1:0] best_prio;
        logic [CNT_W-1:0]  best_rank;
        logic [ID_W-1:0]   best_id;
    } t_carry;
endpackage

// ===== rtl/rrds_cmd_if.sv =====
// Command channel of the scheduler.
interface rrds_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [4:0]  task_id;
    logic [4:0]  priority_req;
    logic [31:0] delay_ticks;
    modport source (output valid, command, task_id, priority_req, delay_ticks, input ready);
    modport sink (input valid, command, task_id, priority_req, delay_ticks, output ready);
endinterface

// ===== rtl/rrds_res_if.sv =====
// Result channel of the scheduler.
interface rrds_res_if;
    logic       valid;
    logic       ready;
    logic [4:0] next_task;
    logic       any_ready;
    logic [5:0] woken_count;
    logic       status;
    modport source (output valid, next_task, any_ready, woken_count, status, input ready);
    modport sink (input valid, next_task, any_ready, woken_count, status, output ready);
endinterface

// ===== rtl/rrds_cell.sv =====
// One task slot: list membership, order keys and its stage of the scan chain.
module rrds_cell #(
    parameter int IDX        = 0,
    parameter int DELAY_BITS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  rrds_pkg::t_bcast       i_bc,
    input  logic [DELAY_BITS-1:0]  i_d,
    input  rrds_pkg::t_carry       i_carry,
    output rrds_pkg::t_carry       o_carry
);
    import rrds_pkg::*;

    logic                  r_in_ready;
    logic                  r_in_delay;
    logic [PRIO_W-1:0]     r_prio;
    logic [CNT_W-1:0]      r_rank;
    logic [CNT_W-1:0]      r_dpos;
    logic [DELAY_BITS-1:0] r_cum;      // cumulative delay from list head
    t_carry                r_carry;
    t_carry                n_carry;
    logic                  me;
    logic [DELAY_BITS-1:0] cum_dec;

    assign me      = (i_bc.tgt == ID_W'(IDX));
    assign cum_dec = i_bc.dec ? (r_cum - DELAY_BITS'(1)) : r_cum;
    assign o_carry = r_carry;

    always_comb begin
        n_carry = i_carry;
        if (me) begin
            n_carry.hit_ready = r_in_ready;
            n_carry.hit_delay = r_in_delay;
            n_carry.hit_rank  = r_rank;
            n_carry.hit_dpos  = r_dpos;
        end
        if (r_in_delay) begin
            if (r_cum < i_d)
                n_carry.lt_cnt = i_carry.lt_cnt + CNT_W'(1);
            if (r_cum == '0)
                n_carry.z_cnt = i_carry.z_cnt + CNT_W'(1);
            if (r_cum == DELAY_BITS'(1))
                n_carry.o_cnt = i_carry.o_cnt + CNT_W'(1);
        end
        if (r_in_ready && (!i_carry.best_vld || r_prio < i_carry.best_prio ||
            (r_prio == i_carry.best_prio && r_rank < i_carry.best_rank))) begin
            n_carry.best_vld  = 1'b1;
            n_carry.best_prio = r_prio;
            n_carry.best_rank = r_rank;
            n_carry.best_id   = ID_W'(IDX);
        end
    end

    always_ff @(posedge i_clk) begin
        r_carry <= n_carry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_ready <= 1'b0;
            r_in_delay <= 1'b0;
        end else begin
            case (i_bc.op)
                OP_RADD: begin
                    if (me) begin
                        r_in_ready <= 1'b1;
                        r_prio     <= i_bc.prio;
                        r_rank     <= i_bc.rdy_cnt;
                    end
                end
                OP_RREM: begin
                    if (me)
                        r_in_ready <= 1'b0;
                    else if (r_in_ready && r_rank > i_bc.tr_rank)
                        r_rank <= r_rank - CNT_W'(1);
                end
                OP_DLINK: begin
                    if (me) begin
                        r_in_delay <= 1'b1;
                        r_prio     <= i_bc.prio;
                        r_cum      <= i_d;
                        r_dpos     <= i_bc.ins_pos;
                    end else if (r_in_delay && r_dpos >= i_bc.ins_pos) begin
                        r_dpos <= r_dpos + CNT_W'(1);
                    end
                end
                OP_DREM: begin
                    if (me)
                        r_in_delay <= 1'b0;
                    else if (r_in_delay && r_dpos > i_bc.tr_dpos)
                        r_dpos <= r_dpos - CNT_W'(1);
                end
                OP_TICK: begin
                    if (r_in_delay) begin
                        // woken tasks join the ready lists in delay-list order
                        if (cum_dec == '0) begin
                            r_in_delay <= 1'b0;
                            r_in_ready <= 1'b1;
                            r_rank     <= i_bc.rdy_cnt + r_dpos;
                        end else begin
                            r_cum  <= cum_dec;
                            r_dpos <= r_dpos - i_bc.k;
                        end
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

// ===== rtl/rtos_ready_and_delay_scheduler_unit.sv =====
// Top level: command sequencer over a row of task-slot cells.
//   channel | dir | payload
//   i_cmd   | in  | command, task_id, priority_req, delay_ticks
//   o_res   | out | next_task, any_ready, woken_count, status
// Each request walks the scan chain through the cells once to gather the
// target and counts, applies the update, and walks the chain once more to
// find the new ready head after the update.
// Synchronous active-low reset clears all list membership at once.
// A finished result waits in the output register; the next request is taken
// meanwhile, and the sequencer holds before loading a new result until taken.
`include "rtos_ready_and_delay_scheduler_unit_assert.svh"
module rtos_ready_and_delay_scheduler_unit #(
    parameter int PRIO_LEVELS = 32,
    parameter int TASK_SLOTS  = 32,
    parameter int DELAY_BITS  = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rrds_cmd_if.sink   i_cmd,
    rrds_res_if.source o_res
);
    import rrds_pkg::*;

    localparam int SCW = $clog2(TASK_SLOTS + 1);
    localparam logic [63:0] DMAX = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - DELAY_BITS);

    typedef enum logic [2:0] {S_IDLE, S_SCAN1, S_APPLY, S_SCAN2, S_DONE} t_state;

    t_state                r_state;
    logic [SCW-1:0]        r_cnt;
    logic [2:0]            r_cmd;
    logic [4:0]            r_tid;
    logic [4:0]            r_prio;
    logic [DELAY_BITS-1:0] r_d;
    logic [CNT_W-1:0]      r_rdy_cnt;
    logic [CNT_W-1:0]      r_dly_cnt;
    logic [5:0]            r_woken;
    logic                  r_status;
    logic                  r_out_vld;
    logic [4:0]            r_next;
    logic                  r_any;
    logic [5:0]            r_out_woken;
    logic                  r_out_status;

    t_carry                w_carry [TASK_SLOTS+1];
    t_carry                c_tail;
    t_bcast                bc;
    logic [63:0]           d_ext;
    logic [63:0]           d_sat;
    logic                  slot_ok;
    logic                  prio_ok;
    logic                  free;
    logic                  bad_prio;
    logic [CNT_W-1:0]      k;
    logic [CNT_W-1:0]      n_rdy_cnt;
    logic [CNT_W-1:0]      n_dly_cnt;
    logic                  acc;
    logic                  ld_out;

    assign w_carry[0] = '0;
    assign c_tail     = w_carry[TASK_SLOTS];
    assign acc        = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = (r_state == S_IDLE);
    assign ld_out     = (r_state == S_DONE) && (!r_out_vld || o_res.ready);

    assign d_ext = {32'd0, i_cmd.delay_ticks};
    assign d_sat = (d_ext > DMAX) ? DMAX : d_ext;

    assign slot_ok  = (32'(r_tid) < TASK_SLOTS);
    assign prio_ok  = (32'(r_prio) < PRIO_LEVELS);
    assign free     = !c_tail.hit_ready && !c_tail.hit_delay;
    assign bad_prio = (r_cmd == CMD_RADD || r_cmd == CMD_DINS) && !prio_ok;
    assign k        = (c_tail.z_cnt != '0) ? c_tail.z_cnt : c_tail.o_cnt;

    always_comb begin
        bc         = '0;
        bc.op      = OP_NONE;
        bc.tgt     = ID_W'(r_tid);
        bc.prio    = r_prio;
        bc.rdy_cnt = r_rdy_cnt;
        bc.tr_rank = c_tail.hit_rank;
        bc.tr_dpos = c_tail.hit_dpos;
        bc.ins_pos = c_tail.lt_cnt;
        bc.k       = k;
        bc.dec     = (c_tail.z_cnt == '0);
        n_rdy_cnt  = r_rdy_cnt;
        n_dly_cnt  = r_dly_cnt;
        if (r_state == S_APPLY && !bad_prio) begin
            case (r_cmd)
                CMD_RADD: begin
                    if (slot_ok && free) begin
                        bc.op     = OP_RADD;
                        n_rdy_cnt = r_rdy_cnt + CNT_W'(1);
                    end
                end
                CMD_RREM: begin
                    if (slot_ok && c_tail.hit_ready) begin
                        bc.op     = OP_RREM;
                        n_rdy_cnt = r_rdy_cnt - CNT_W'(1);
                    end
                end
                CMD_DINS: begin
                    if (slot_ok && free) begin
                        // zero delay goes straight to the ready list
                        if (r_d == '0) begin
                            bc.op     = OP_RADD;
                            n_rdy_cnt = r_rdy_cnt + CNT_W'(1);
                        end else begin
                            bc.op     = OP_DLINK;
                            n_dly_cnt = r_dly_cnt + CNT_W'(1);
                        end
                    end
                end
                CMD_DREM: begin
                    if (slot_ok && c_tail.hit_delay) begin
                        bc.op     = OP_DREM;
                        n_dly_cnt = r_dly_cnt - CNT_W'(1);
                    end
                end
                CMD_TICK: begin
                    bc.op     = OP_TICK;
                    n_rdy_cnt = r_rdy_cnt + k;
                    n_dly_cnt = r_dly_cnt - k;
                end
                default: ;
            endcase
        end
    end

    for (genvar gi = 0; gi < TASK_SLOTS; gi++) begin : g_cell
        rrds_cell #(
            .IDX        (gi),
            .DELAY_BITS (DELAY_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_bc    (bc),
            .i_d     (r_d),
            .i_carry (w_carry[gi]),
            .o_carry (w_carry[gi+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_rdy_cnt <= '0;
            r_dly_cnt <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (ld_out)
                r_out_vld <= 1'b1;
            else if (o_res.valid && o_res.ready)
                r_out_vld <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        r_cmd   <= i_cmd.command;
                        r_tid   <= i_cmd.task_id;
                        r_prio  <= i_cmd.priority_req;
                        r_d     <= d_sat[DELAY_BITS-1:0];
                        r_cnt   <= '0;
                        r_state <= S_SCAN1;
                    end
                end
                S_SCAN1: begin
                    r_cnt <= r_cnt + SCW'(1);
                    if (r_cnt == SCW'(TASK_SLOTS - 1))
                        r_state <= S_APPLY;
                end
                S_APPLY: begin
                    r_rdy_cnt <= n_rdy_cnt;
                    r_dly_cnt <= n_dly_cnt;
                    r_status  <= bad_prio;
                    r_woken   <= (r_cmd == CMD_TICK) ? k[5:0] : 6'd0;
                    r_cnt     <= '0;
                    r_state   <= S_SCAN2;
                end
                S_SCAN2: begin
                    r_cnt <= r_cnt + SCW'(1);
                    if (r_cnt == SCW'(TASK_SLOTS - 1))
                        r_state <= S_DONE;
                end
                S_DONE: begin
                    if (ld_out) begin
                        r_any        <= c_tail.best_vld;
                        r_next       <= c_tail.best_vld ? c_tail.best_id[4:0] : 5'd0;
                        r_out_woken  <= r_woken;
                        r_out_status <= r_status;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.valid       = r_out_vld;
    assign o_res.next_task   = r_next;
    assign o_res.any_ready   = r_any;
    assign o_res.woken_count = r_out_woken;
    assign o_res.status      = r_out_status;

    `RRDS_ASSERT_HOLD(a_slot_total, i_clk, i_rst_n, 32'(r_rdy_cnt) + 32'(r_dly_cnt) <= TASK_SLOTS)
    `RRDS_ASSERT_NEXT(a_acc_scan, i_clk, i_rst_n, acc, r_state == S_SCAN1 && r_cnt == '0)
    `RRDS_ASSERT_NEXT(a_apply_scan, i_clk, i_rst_n, r_state == S_APPLY, r_state == S_SCAN2 && r_cnt == '0)
    `RRDS_ASSERT_NEXT(a_done_load, i_clk, i_rst_n, r_state == S_DONE && !r_out_vld, r_out_vld && r_state == S_IDLE)
endmodule

// ===== tb/rtos_ready_and_delay_scheduler_unit_tb.sv =====
// Self-checking testbench for the ready-list and delay-list scheduler.
module rtos_ready_and_delay_scheduler_unit_tb;
    import rrds_pkg::*;

    localparam int          SLOTS      = 32;
    localparam int          NIL        = SLOTS;
    localparam logic [2:0]  CMD_QUERY  = 3'd5;
    localparam logic [2:0]  CMD_SPARE6 = 3'd6;
    localparam logic [2:0]  CMD_SPARE7 = 3'd7;
    localparam int          STALL_LIMIT = 3000;
    localparam int          HOLD_CYCLES = 500;

    typedef struct packed {
        logic [4:0] next_task;
        logic       any_ready;
        logic [5:0] woken_count;
        logic       status;
    } t_sched_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rrds_cmd_if cmd_ch ();
    rrds_res_if res_ch ();

    rtos_ready_and_delay_scheduler_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch.sink),
        .o_res   (res_ch.source)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // scheduler shadow state
    logic [4:0]  task_level [SLOTS];
    int          rdy_next [SLOTS];
    int          rdy_prev [SLOTS];
    int          lvl_head [32];
    int          lvl_tail [32];
    logic [31:0] level_map;
    int          dly_next [SLOTS];
    int          dly_prev [SLOTS];
    logic [31:0] dly_delta [SLOTS];
    int          dly_head;
    int          dly_tail;
    bit          is_ready [SLOTS];
    bit          is_delayed [SLOTS];

    t_sched_result expected_results [$];
    int mismatches;
    int cmd_seen [8];
    int total_woken;
    bit quiet;
    bit holding;
    event hold_go;

    function automatic void sched_reset();
        for (int i = 0; i < 32; i++) begin
            lvl_head[i] = NIL;
            lvl_tail[i] = NIL;
        end
        for (int i = 0; i < SLOTS; i++) begin
            is_ready[i]   = 1'b0;
            is_delayed[i] = 1'b0;
        end
        level_map = '0;
        dly_head  = NIL;
        dly_tail  = NIL;
    endfunction

    function automatic void ready_append(int t, logic [4:0] p);
        task_level[t] = p;
        rdy_next[t]   = NIL;
        rdy_prev[t]   = lvl_tail[p];
        if (lvl_head[p] == NIL)
            lvl_head[p] = t;
        else
            rdy_next[lvl_tail[p]] = t;
        lvl_tail[p]   = t;
        is_ready[t]   = 1'b1;
        level_map[31 - p] = 1'b1;
    endfunction

    function automatic void ready_drop(int t);
        logic [4:0] p;
        int pv, nx;
        p  = task_level[t];
        pv = rdy_prev[t];
        nx = rdy_next[t];
        if (pv < SLOTS) rdy_next[pv] = nx;
        else lvl_head[p] = nx;
        if (nx < SLOTS) rdy_prev[nx] = pv;
        else lvl_tail[p] = pv;
        is_ready[t] = 1'b0;
        if (lvl_head[p] == NIL)
            level_map[31 - p] = 1'b0;
    endfunction

    function automatic void delay_drop(int t);
        int pv, nx;
        pv = dly_prev[t];
        nx = dly_next[t];
        if (pv < SLOTS) dly_next[pv] = nx;
        else dly_head = nx;
        if (nx < SLOTS) begin
            dly_prev[nx]  = pv;
            dly_delta[nx] = dly_delta[nx] + dly_delta[t];
        end else begin
            dly_tail = pv;
        end
        is_delayed[t] = 1'b0;
    endfunction

    function automatic void delay_place(int t, logic [31:0] d);
        int cur, pv, guard;
        cur = dly_head;
        pv = NIL;
        guard = 0;
        while (cur < SLOTS && guard < SLOTS && d > dly_delta[cur]) begin
            d   = d - dly_delta[cur];
            pv  = cur;
            cur = dly_next[cur];
            guard++;
        end
        dly_delta[t] = d;
        dly_prev[t]  = pv;
        dly_next[t]  = cur;
        if (cur != NIL) begin
            dly_delta[cur] = dly_delta[cur] - d;
            dly_prev[cur]  = t;
        end else begin
            dly_tail = t;
        end
        if (pv != NIL) dly_next[pv] = t;
        else dly_head = t;
        is_delayed[t] = 1'b1;
    endfunction

    function automatic int advance_tick();
        int woken, h;
        woken = 0;
        h = dly_head;
        if (h >= SLOTS) return 0;
        if (dly_delta[h] != 0) dly_delta[h] = dly_delta[h] - 1;
        while (h < SLOTS && dly_delta[h] == 0 && woken < SLOTS) begin
            delay_drop(h);
            ready_append(h, task_level[h]);
            woken++;
            h = dly_head;
        end
        return woken;
    endfunction

    function automatic t_sched_result schedule_step(logic [2:0] c, logic [4:0] t,
                                                    logic [4:0] p, logic [31:0] d);
        t_sched_result r;
        r = '0;
        // five-bit priority cannot exceed the level count, so status stays clear
        case (c)
            CMD_RADD: if (!is_ready[t] && !is_delayed[t]) ready_append(t, p);
            CMD_RREM: if (is_ready[t]) ready_drop(t);
            CMD_DINS: begin
                if (!is_ready[t] && !is_delayed[t]) begin
                    if (d == 0) begin
                        ready_append(t, p);
                    end else begin
                        task_level[t] = p;
                        delay_place(t, d);
                    end
                end
            end
            CMD_DREM: if (is_delayed[t]) delay_drop(t);
            CMD_TICK: r.woken_count = 6'(advance_tick());
            default: ;
        endcase
        for (int i = 0; i < 32; i++) begin
            if (level_map[31 - i]) begin
                r.next_task = 5'(lvl_head[i]);
                r.any_ready = 1'b1;
                break;
            end
        end
        return r;
    endfunction

    task automatic send_request(logic [2:0] c, logic [4:0] t, logic [4:0] p,
                                logic [31:0] d);
        cmd_ch.valid        <= 1'b1;
        cmd_ch.command      <= c;
        cmd_ch.task_id      <= t;
        cmd_ch.priority_req <= p;
        cmd_ch.delay_ticks  <= d;
        do @(posedge i_clk); while (!cmd_ch.ready);
        expected_results.push_back(schedule_step(c, t, p, d));
        cmd_seen[c]++;
        if (!quiet && $urandom_range(99) < 21) begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(8, 1)) @(posedge i_clk);
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_sched_result got, exp_r;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got = {res_ch.next_task, res_ch.any_ready, res_ch.woken_count, res_ch.status};
            if (got.woken_count != 0) total_woken += got.woken_count;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", got);
            end else begin
                exp_r = expected_results.pop_front();
                if (got !== exp_r) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", exp_r, got);
                end
            end
        end
    end

    // result-side back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) res_ch.ready <= 1'b0;
        else res_ch.ready <= !holding && (quiet || $urandom_range(99) >= 21);
    end

    initial begin
        holding = 1'b0;
        forever begin
            @hold_go;
            holding = 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            holding = 1'b0;
        end
    end

    // stall watchdog
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("rtos_ready_and_delay_scheduler_unit test failed");
                $finish;
            end
        end
    end

    task automatic test_empty_and_spare();
        send_request(CMD_QUERY, 5'd0, 5'd0, 32'd0);
        send_request(CMD_TICK, 5'd0, 5'd0, 32'd0);
        send_request(CMD_RREM, 5'd3, 5'd0, 32'd0);
        send_request(CMD_DREM, 5'd3, 5'd0, 32'd0);
        send_request(CMD_SPARE6, 5'd31, 5'd31, 32'hFFFF_FFFF);
        send_request(CMD_SPARE7, 5'd0, 5'd0, 32'd0);
    endtask

    task automatic test_ready_lists();
        send_request(CMD_RADD, 5'd31, 5'd31, 32'd0);
        send_request(CMD_RADD, 5'd0, 5'd31, 32'd0);
        send_request(CMD_RADD, 5'd7, 5'd0, 32'd0);
        send_request(CMD_RADD, 5'd8, 5'd0, 32'd0);
        send_request(CMD_RADD, 5'd7, 5'd4, 32'd0);   // already listed
        send_request(CMD_RREM, 5'd7, 5'd0, 32'd0);   // head leaves
        send_request(CMD_RREM, 5'd8, 5'd0, 32'd0);
        send_request(CMD_RREM, 5'd31, 5'd0, 32'd0);
    endtask

    task automatic test_delay_list();
        send_request(CMD_DINS, 5'd12, 5'd2, 32'd0);       // straight to ready
        send_request(CMD_DINS, 5'd13, 5'd3, 32'hFFFF_FFFF);
        send_request(CMD_DINS, 5'd14, 5'd1, 32'd3);
        send_request(CMD_DINS, 5'd15, 5'd1, 32'd3);       // equal delta, zero gap
        send_request(CMD_DINS, 5'd16, 5'd5, 32'd1);       // new head, tail kept
        send_request(CMD_DINS, 5'd14, 5'd9, 32'd5);       // already delayed
        send_request(CMD_TICK, 5'd0, 5'd0, 32'd0);
        send_request(CMD_DREM, 5'd13, 5'd0, 32'd0);
        send_request(CMD_TICK, 5'd0, 5'd0, 32'd0);
        send_request(CMD_TICK, 5'd0, 5'd0, 32'd0);
    endtask

    task automatic test_backpressure();
        ->hold_go;
        for (int i = 0; i < 12; i++)
            send_request(3'($urandom_range(5)), 5'($urandom), 5'($urandom),
                         32'($urandom_range(4)));
    endtask

    task automatic test_random(int count);
        logic [2:0] c;
        logic [31:0] d;
        int pick;
        for (int i = 0; i < count; i++) begin
            quiet = (i >= 250 && i < 350);
            pick = $urandom_range(99);
            if (pick < 25) c = CMD_RADD;
            else if (pick < 38) c = CMD_RREM;
            else if (pick < 60) c = CMD_DINS;
            else if (pick < 70) c = CMD_DREM;
            else if (pick < 94) c = CMD_TICK;
            else c = 3'($urandom_range(7, 5));
            pick = $urandom_range(99);
            if (pick < 10) d = '0;
            else if (pick < 65) d = $urandom_range(6, 1);
            else if (pick < 90) d = $urandom_range(40, 7);
            else d = $urandom;
            send_request(c, 5'($urandom), 5'($urandom), d);
        end
        quiet = 1'b0;
    endtask

    initial begin
        i_rst_n             = 1'b0;
        cmd_ch.valid        = 1'b0;
        cmd_ch.command      = '0;
        cmd_ch.task_id      = '0;
        cmd_ch.priority_req = '0;
        cmd_ch.delay_ticks  = '0;
        quiet               = 1'b0;
        mismatches          = 0;
        total_woken         = 0;
        foreach (cmd_seen[i]) cmd_seen[i] = 0;
        sched_reset();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_and_spare();
        test_ready_lists();
        test_delay_list();
        test_backpressure();
        test_random(600);
        cmd_ch.valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (expected_results.size() != 0) mismatches++;

        $display("requests: add %0d, remove %0d, delay %0d, undelay %0d, tick %0d, query %0d",
                 cmd_seen[CMD_RADD], cmd_seen[CMD_RREM], cmd_seen[CMD_DINS],
                 cmd_seen[CMD_DREM], cmd_seen[CMD_TICK],
                 cmd_seen[CMD_QUERY] + cmd_seen[CMD_SPARE6] + cmd_seen[CMD_SPARE7]);
        $display("tasks woken by ticks: %0d, mismatches: %0d", total_woken, mismatches);
        if (mismatches == 0)
            $display("rtos_ready_and_delay_scheduler_unit test passed");
        else
            $display("rtos_ready_and_delay_scheduler_unit test failed");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/rrds_pkg.sv
rtl/rrds_cmd_if.sv
rtl/rrds_res_if.sv
rtl/rrds_cell.sv
rtl/rtos_ready_and_delay_scheduler_unit.sv
tb/rtos_ready_and_delay_scheduler_unit_tb.sv
